### hdl/multichannel_window_median_assert.svh
// assertion macros for the multichannel window median block
// used by the top level; needs a clock named clk and a reset named rst in scope
`ifndef MULTICHANNEL_WINDOW_MEDIAN_ASSERT_SVH
`define MULTICHANNEL_WINDOW_MEDIAN_ASSERT_SVH

// antecedent holds -> consequent holds in the same cycle
`define MWM_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// antecedent holds -> consequent holds in the next cycle
`define MWM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/mwm_pkg.sv
// shared types and constants for the multichannel window median block
// no dependencies
`timescale 1ns / 1ps

package mwm_pkg;

  // default configuration
  localparam int DEFAULT_WINDOW      = 50;
  localparam int DEFAULT_CHANNELS    = 3;
  localparam int DEFAULT_SAMPLE_BITS = 12;

  // fixed field widths
  localparam int CHANNEL_W = 2;
  localparam int SAMPLE_W  = 12;
  localparam int MEDIAN_W  = 12;

  // operation codes
  localparam logic OP_STORE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // control from the sequencer to the rank sorter
  typedef struct packed {
    logic init;    // preload every cell with the largest value
    logic insert;  // insert the sample on the data input
  } sort_ctrl_t;

endpackage

### hdl/mwm_rank_sorter.sv
// insertion sorter that keeps the smallest CELLS values seen since init
// depends on mwm_pkg
`timescale 1ns / 1ps

module mwm_rank_sorter
  import mwm_pkg::*;
#(
  parameter int SAMPLE_BITS = DEFAULT_SAMPLE_BITS,
  parameter int CELLS       = (DEFAULT_WINDOW - 1) / 2 + 1
) (
  input  logic                   clk,
  input  sort_ctrl_t             ctrl,
  input  logic [SAMPLE_BITS-1:0] din,
  output logic [SAMPLE_BITS-1:0] rank_value
);

  logic [SAMPLE_BITS-1:0] cells [CELLS];
  logic [CELLS-1:0]       lt;

  // cells stay ascending, so lt is a thermometer code
  always_comb begin
    for (int i = 0; i < CELLS; i++) begin
      lt[i] = (din < cells[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.init) begin
      for (int i = 0; i < CELLS; i++) begin
        cells[i] <= '1;
      end
    end else if (ctrl.insert) begin
      if (lt[0]) begin
        cells[0] <= din;
      end
      for (int i = 1; i < CELLS; i++) begin
        if (lt[i]) begin
          cells[i] <= lt[i-1] ? cells[i-1] : din;
        end
      end
    end
  end

  assign rank_value = cells[CELLS-1];

endmodule

### hdl/multichannel_window_median.sv
// top level of the multichannel sliding window median filter
// depends on mwm_pkg, mwm_rank_sorter and multichannel_window_median_assert.svh
`timescale 1ns / 1ps
`include "multichannel_window_median_assert.svh"

// Keeps the last WINDOW samples of each of CHANNELS channels in one sample
// memory (CHANNELS*WINDOW entries, one write and one registered read port).
// A store transaction (operation 0) writes its sample at the channel's ring
// position in the cycle it is accepted and gives no result; the sequencer
// stays idle through it. A query transaction (operation 1) walks the
// channel's window through the read port, one entry per cycle, and feeds
// each entry into an insertion sorter that keeps the (WINDOW-1)/2+1 smallest
// values; the last of them is the lower median. A query keeps in_stall high
// through its read, drain and done states, since the walk holds the single
// memory read port; the result then waits in the output register, so the
// next transaction is taken while it is still stalled. A query that finishes
// while the previous result is still stalled holds until the output frees.
// Transactions on a channel number not below CHANNELS are accepted and
// dropped. After reset a clearing pass writes zero to every memory entry, one
// per cycle; in_stall is high until it ends.
module multichannel_window_median
  import mwm_pkg::*;
#(
  parameter int WINDOW      = DEFAULT_WINDOW,
  parameter int CHANNELS    = DEFAULT_CHANNELS,
  parameter int SAMPLE_BITS = DEFAULT_SAMPLE_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  // input transaction channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 operation,
  input  logic [CHANNEL_W-1:0] channel,
  input  logic [SAMPLE_W-1:0]  sample,
  // result transaction channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [MEDIAN_W-1:0]  median,
  output logic [CHANNEL_W-1:0] result_channel
);

  localparam int DEPTH    = CHANNELS * WINDOW;
  localparam int ADDR_W   = $clog2(DEPTH);
  localparam int POS_W    = $clog2(WINDOW);
  localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int RANK     = (WINDOW - 1) >> 1;

  // sequencer states
  localparam logic [2:0] ST_CLEAR = 3'd0;  // clearing pass after reset
  localparam logic [2:0] ST_IDLE  = 3'd1;  // ready for a transaction
  localparam logic [2:0] ST_READ  = 3'd2;  // issuing window reads
  localparam logic [2:0] ST_DRAIN = 3'd3;  // last read data into the sorter
  localparam logic [2:0] ST_DONE  = 3'd4;  // median ready, waiting for output

  logic [2:0]             state;
  logic [ADDR_W-1:0]      clr_cnt;
  logic [POS_W-1:0]       rd_cnt;
  logic [ADDR_W-1:0]      base;
  logic [CHANNEL_W-1:0]   qchan;
  logic                   rd_pending;

  // sample memory and its ring positions
  logic [SAMPLE_BITS-1:0] mem [DEPTH];
  logic [SAMPLE_BITS-1:0] mem_rd;
  logic [POS_W-1:0]       write_position [CHANNELS];

  logic                   in_accept;
  logic                   ch_ok;
  logic [CH_IDX_W-1:0]    ch_idx;
  logic                   store_go;
  logic                   query_go;
  logic [POS_W-1:0]       pos_cur;
  logic [POS_W-1:0]       pos_next;
  logic                   wr_en;
  logic [ADDR_W-1:0]      wr_addr;
  logic [SAMPLE_BITS-1:0] wr_data;
  logic [ADDR_W-1:0]      rd_addr;
  logic                   out_free;
  sort_ctrl_t             sort_ctrl;
  logic [SAMPLE_BITS-1:0] rank_value;

  // input side decode
  assign in_stall  = (state != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign ch_ok     = (int'(channel) < CHANNELS);
  assign ch_idx    = CH_IDX_W'(channel);
  assign store_go  = in_accept && ch_ok && (operation == OP_STORE);
  assign query_go  = in_accept && ch_ok && (operation == OP_QUERY);

  // ring position of the addressed channel, wraps after the last slot
  assign pos_cur  = write_position[ch_idx];
  assign pos_next = (int'(pos_cur) == WINDOW - 1) ? '0 : pos_cur + 1'b1;

  // write port: clearing pass or a store
  assign wr_en   = (state == ST_CLEAR) || store_go;
  assign wr_addr = (state == ST_CLEAR) ? clr_cnt
                                       : ADDR_W'(int'(ch_idx) * WINDOW + int'(pos_cur));
  assign wr_data = (state == ST_CLEAR) ? '0 : SAMPLE_BITS'(sample);

  // read port walks the queried channel's window
  assign rd_addr = base + ADDR_W'(rd_cnt);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    mem_rd <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        write_position[i] <= '0;
      end
    end else if (store_go) begin
      write_position[ch_idx] <= pos_next;
    end
  end

  // sorter is preloaded when a query is accepted and takes each read word
  assign sort_ctrl.init   = query_go;
  assign sort_ctrl.insert = rd_pending;

  mwm_rank_sorter #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .CELLS       (RANK + 1)
  ) u_sorter (
    .clk        (clk),
    .ctrl       (sort_ctrl),
    .din        (mem_rd),
    .rank_value (rank_value)
  );

  assign out_free = !out_valid || !out_stall;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clr_cnt    <= '0;
      rd_cnt     <= '0;
      rd_pending <= 1'b0;
    end else begin
      rd_pending <= (state == ST_READ);
      unique case (state)
        ST_CLEAR: begin
          if (int'(clr_cnt) == DEPTH - 1) begin
            state <= ST_IDLE;
          end else begin
            clr_cnt <= clr_cnt + 1'b1;
          end
        end
        ST_IDLE: begin
          rd_cnt <= '0;
          if (query_go) begin
            state <= ST_READ;
          end
        end
        ST_READ: begin
          if (int'(rd_cnt) == WINDOW - 1) begin
            state <= ST_DRAIN;
          end else begin
            rd_cnt <= rd_cnt + 1'b1;
          end
        end
        ST_DRAIN: begin
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // query context, no reset needed
  always_ff @(posedge clk) begin
    if (query_go) begin
      base  <= ADDR_W'(int'(ch_idx) * WINDOW);
      qchan <= channel;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      median         <= MEDIAN_W'(rank_value);
      result_channel <= qchan;
    end
  end

  // checks
  `MWM_ASSERT_SAME(a_no_write_in_walk, (state == ST_READ || state == ST_DRAIN), !wr_en, "memory written during a window walk")
  `MWM_ASSERT_SAME(a_result_from_done, $rose(out_valid), $past(state) == ST_DONE, "result raised outside a finished query")
  `MWM_ASSERT_NEXT(a_walk_ends_in_drain, (state == ST_READ && int'(rd_cnt) == WINDOW - 1), state == ST_DRAIN && rd_pending, "window walk did not end in drain")

endmodule
